// ===== hdl/cst_pkg.sv =====
// Shared definitions for the character stream tokenizer: token kinds, scan modes,
// character codes and character class functions.
// No dependencies.
`default_nettype none

package cst_pkg;

   localparam int KIND_BITS = 4;
   localparam int CHAR_BITS = 8;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_IDENT  = 4'd0,
      KIND_NUMBER = 4'd1,
      KIND_COLON  = 4'd2,
      KIND_LPAREN = 4'd3,
      KIND_RPAREN = 4'd4,
      KIND_LBRACE = 4'd5,
      KIND_RBRACE = 4'd6,
      KIND_EQUAL  = 4'd7,
      KIND_SEMI   = 4'd8,
      KIND_ARROW  = 4'd9,
      KIND_DASH   = 4'd10,
      KIND_GT     = 4'd11,
      KIND_END    = 4'd12
   } tok_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_DASH   = 2'd3
   } tok_mode_type;

   // One delimiter lookup result.
   typedef struct packed {
      logic         hit;
      tok_kind_type kind;
   } tok_delim_type;

   localparam logic [CHAR_BITS-1:0] CHAR_NUL        = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT        = 8'h2e;
   localparam logic [CHAR_BITS-1:0] CHAR_GT         = 8'h3e;
   localparam logic [CHAR_BITS-1:0] CHAR_DASH       = 8'h2d;
   localparam logic [CHAR_BITS-1:0] CHAR_COLON      = 8'h3a;
   localparam logic [CHAR_BITS-1:0] CHAR_LPAREN     = 8'h28;
   localparam logic [CHAR_BITS-1:0] CHAR_RPAREN     = 8'h29;
   localparam logic [CHAR_BITS-1:0] CHAR_LBRACE     = 8'h7b;
   localparam logic [CHAR_BITS-1:0] CHAR_RBRACE     = 8'h7d;
   localparam logic [CHAR_BITS-1:0] CHAR_EQUAL      = 8'h3d;
   localparam logic [CHAR_BITS-1:0] CHAR_SEMI       = 8'h3b;

   function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic tok_delim_type delim_kind(input logic [CHAR_BITS-1:0] c);
      tok_delim_type d;
      d.hit  = 1'b1;
      d.kind = KIND_COLON;
      unique case (c)
         CHAR_COLON:  d.kind = KIND_COLON;
         CHAR_LPAREN: d.kind = KIND_LPAREN;
         CHAR_RPAREN: d.kind = KIND_RPAREN;
         CHAR_LBRACE: d.kind = KIND_LBRACE;
         CHAR_RBRACE: d.kind = KIND_RBRACE;
         CHAR_EQUAL:  d.kind = KIND_EQUAL;
         CHAR_SEMI:   d.kind = KIND_SEMI;
         CHAR_GT:     d.kind = KIND_GT;
         default:     d.hit  = 1'b0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/cst_queue.sv =====
// Result queue for the tokenizer: takes zero, one or two results per cycle and
// hands out one per cycle at its head while pop is high. Depends on nothing but its parameters.
`default_nettype none

module cst_queue #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [1:0]                   push_cnt,
   input  wire logic [WIDTH-1:0]             push_data0,
   input  wire logic [WIDTH-1:0]             push_data1,
   input  wire logic                         pop,
   output      logic [WIDTH-1:0]             head_data,
   output      logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [PW-1:0]    wr_next;
   logic [PW-1:0]    wr_next2;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_next   = ptr_inc(wr_ptr_ff);
      wr_next2  = ptr_inc(wr_next);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_cnt) - CW'(pop);
      unique case (push_cnt)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_next;
         default: wr_ptr_in = wr_next2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= push_data1;
      end
   end

   assign head_data = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== hdl/cst_scan.sv =====
// Scanner for the tokenizer: input byte register, scan state and the single
// pass that turns one byte into up to two packed results. Depends on cst_pkg.
`default_nettype none

module cst_scan #(
   parameter int OFFSET_BITS = 16,
   parameter int LENGTH_BITS = 8,
   parameter int RES_BITS    = cst_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS + 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           take,
   input  wire logic [cst_pkg::CHAR_BITS-1:0]  char_code,
   output      logic                           busy,
   output      logic [1:0]                     push_cnt,
   output      logic [RES_BITS-1:0]            res0,
   output      logic [RES_BITS-1:0]            res1
);

   import cst_pkg::*;

   logic                   in_valid_ff;
   logic [CHAR_BITS-1:0]   char_ff;
   tok_mode_type           mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   logic                   a_valid, b_valid, consumed;
   tok_kind_type           a_kind, b_kind;
   logic [OFFSET_BITS-1:0] a_start, b_start;
   logic [LENGTH_BITS-1:0] a_length, b_length;
   logic [LENGTH_BITS-1:0] length_sat;
   tok_delim_type          delim;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         start_ff    <= '0;
         length_ff   <= '0;
         offset_ff   <= '0;
      end else begin
         in_valid_ff <= take;
         mode_ff     <= mode_in;
         start_ff    <= start_in;
         length_ff   <= length_in;
         offset_ff   <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= char_code;
      end
   end

   always_comb begin
      length_sat = (length_ff == '1) ? length_ff : length_ff + 1'b1;
      delim      = delim_kind(char_ff);
      mode_in    = mode_ff;
      start_in   = start_ff;
      length_in  = length_ff;
      offset_in  = offset_ff;
      consumed   = 1'b0;
      a_valid    = 1'b0;
      a_kind     = KIND_IDENT;
      a_start    = start_ff;
      a_length   = length_ff;
      b_valid    = 1'b0;
      b_kind     = KIND_END;
      b_start    = offset_ff;
      b_length   = LENGTH_BITS'(1);

      if (in_valid_ff) begin
         // Close or extend whatever token is open.
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_letter(char_ff) || is_digit(char_ff) || char_ff == CHAR_UNDERSCORE) begin
                  length_in = length_sat;
                  consumed  = 1'b1;
               end else begin
                  a_valid = 1'b1;
                  a_kind  = KIND_IDENT;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(char_ff) || char_ff == CHAR_DOT) begin
                  length_in = length_sat;
                  consumed  = 1'b1;
               end else begin
                  a_valid = 1'b1;
                  a_kind  = KIND_NUMBER;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_DASH: begin
               a_valid = 1'b1;
               mode_in = MODE_IDLE;
               if (char_ff == CHAR_GT) begin
                  a_kind   = KIND_ARROW;
                  a_length = LENGTH_BITS'(2);
                  consumed = 1'b1;
               end else begin
                  a_kind   = KIND_DASH;
                  a_length = LENGTH_BITS'(1);
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         offset_in = offset_ff + 1'b1;

         // Scan the byte afresh when the open token did not take it.
         if (!consumed) begin
            priority if (char_ff == CHAR_NUL) begin
               b_valid   = 1'b1;
               b_kind    = KIND_END;
               b_length  = '0;
               mode_in   = MODE_IDLE;
               start_in  = '0;
               length_in = '0;
               offset_in = '0;
            end else if (is_letter(char_ff)) begin
               mode_in   = MODE_IDENT;
               start_in  = offset_ff;
               length_in = LENGTH_BITS'(1);
            end else if (is_digit(char_ff)) begin
               mode_in   = MODE_NUMBER;
               start_in  = offset_ff;
               length_in = LENGTH_BITS'(1);
            end else if (char_ff == CHAR_DASH) begin
               mode_in   = MODE_DASH;
               start_in  = offset_ff;
               length_in = LENGTH_BITS'(1);
            end else if (delim.hit) begin
               b_valid = 1'b1;
               b_kind  = delim.kind;
            end else begin
               b_valid = 1'b0;
            end
         end
      end
   end

   always_comb begin
      push_cnt = 2'd0;
      res0     = {a_kind, a_start, a_length, 1'b1};
      res1     = {b_kind, b_start, b_length, 1'b1};
      priority if (a_valid && b_valid) begin
         push_cnt = 2'd2;
         res0     = {a_kind, a_start, a_length, 1'b0};
      end else if (a_valid) begin
         push_cnt = 2'd1;
      end else if (b_valid) begin
         push_cnt = 2'd1;
         res0     = {b_kind, b_start, b_length, 1'b1};
      end else begin
         push_cnt = 2'd0;
      end
   end

   assign busy = in_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/char_stream_tokenizer.sv =====
// Top level of the character stream tokenizer: byte scanner feeding a result queue.
// Depends on cst_pkg, cst_scan and cst_queue.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | char_code
//   rsp_    | out       | rsp_valid/rsp_stall | token_kind, token_start, token_length,
//           |           |                     | last_result
//
// One byte is accepted per cycle while req_stall is low; its results enter the queue
// in the cycle after it is taken and leave at one result per cycle while rsp_stall
// is low, the two results of a byte in turn. The eight-entry result queue sets how far
// the output may stall before req_stall rises; req_stall depends only on registers.
// Synchronous reset empties the queue and returns the scanner to idle at offset zero.
`default_nettype none

module char_stream_tokenizer #(
   parameter int OFFSET_BITS = 16,
   parameter int LENGTH_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [cst_pkg::CHAR_BITS-1:0]       req_char_code,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [cst_pkg::KIND_BITS-1:0]       rsp_token_kind,
   output      logic [OFFSET_BITS-1:0]              rsp_token_start,
   output      logic [LENGTH_BITS-1:0]              rsp_token_length,
   output      logic                                rsp_last_result
);

   import cst_pkg::*;

   localparam int RES_BITS    = KIND_BITS + OFFSET_BITS + LENGTH_BITS + 1;
   localparam int QUEUE_DEPTH = 8;
   localparam int CW          = $clog2(QUEUE_DEPTH + 1);

   logic                take;
   logic                busy;
   logic [1:0]          push_cnt;
   logic [RES_BITS-1:0] res0, res1, head;
   logic [CW-1:0]       count;
   logic [CW:0]         demand;
   logic                pop;

   // Room is kept for the byte in the scanner and for one more, two results each.
   assign demand    = {1'b0, count} + (busy ? (CW+1)'(2) : '0);
   assign req_stall = demand > (CW+1)'(QUEUE_DEPTH - 2);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = count != '0;
   assign pop       = rsp_valid && !rsp_stall;

   cst_scan #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .RES_BITS    (RES_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_char_code),
      .busy      (busy),
      .push_cnt  (push_cnt),
      .res0      (res0),
      .res1      (res1)
   );

   cst_queue #(
      .WIDTH (RES_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_data0 (res0),
      .push_data1 (res1),
      .pop        (pop),
      .head_data  (head),
      .count      (count)
   );

   assign rsp_token_kind   = head[RES_BITS-1 -: KIND_BITS];
   assign rsp_token_start  = head[LENGTH_BITS+OFFSET_BITS : LENGTH_BITS+1];
   assign rsp_token_length = head[LENGTH_BITS:1];
   assign rsp_last_result  = head[0];

endmodule

`default_nettype wire

// ===== hdl/cst_checker.sv =====
// Port-level checks for the character stream tokenizer and the bind that attaches
// them to the top level. Depends on cst_pkg and char_stream_tokenizer.
`default_nettype none

module cst_checker #(
   parameter int OFFSET_BITS = 16,
   parameter int LENGTH_BITS = 8
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [cst_pkg::KIND_BITS-1:0]  rsp_token_kind,
   input wire logic [OFFSET_BITS-1:0]         rsp_token_start,
   input wire logic [LENGTH_BITS-1:0]         rsp_token_length,
   input wire logic                           rsp_last_result
);

   import cst_pkg::*;

   // A transaction waiting on the output keeps its valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // End of source always closes the byte's results and has no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_END |-> rsp_last_result && rsp_token_length == '0)
      else $error("end token without last_result or with nonzero length");

   // An arrow spans the dash and the greater-than sign.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_ARROW |-> rsp_token_length == LENGTH_BITS'(2))
      else $error("arrow token with length other than two");

   // Reset leaves no result pending and the input open.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result pending or input stalled right after reset");

endmodule

bind char_stream_tokenizer cst_checker #(
   .OFFSET_BITS (OFFSET_BITS),
   .LENGTH_BITS (LENGTH_BITS)
) u_cst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_start  (rsp_token_start),
   .rsp_token_length (rsp_token_length),
   .rsp_last_result  (rsp_last_result)
);

`default_nettype wire
